// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the frame checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfc assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define SFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfc assertion failed: next-cycle implication");

`endif

// ----- rtl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg
// shared types and constants of the serial packet frame checker
// ----------------------------------------------------------------------------
package sfc_pkg;

   localparam int unsigned POSITION_BITS = 8;
   localparam int unsigned DATA_BITS     = 8;
   localparam int unsigned CMP_BITS      = (POSITION_BITS > DATA_BITS) ? POSITION_BITS
                                                                       : DATA_BITS;
   localparam int unsigned CMP_EXT_BITS  = CMP_BITS + 1;
   localparam int unsigned CSR_ADDR_BITS = 5;
   localparam int unsigned CSR_DATA_BITS = 32;

   localparam logic [DATA_BITS-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [DATA_BITS-1:0] STAR_CODE    = 8'h2A;

   localparam logic [DATA_BITS-1:0] SYNC_BYTE_RESET        = 8'hFF;
   localparam logic [DATA_BITS-1:0] TYPE_A_CODE_RESET      = 8'hFB;
   localparam logic [DATA_BITS-1:0] TYPE_B_CODE_RESET      = 8'hFD;
   localparam logic [DATA_BITS-1:0] TYPE_A_STAR_SLOT_RESET = 8'd6;
   localparam logic [DATA_BITS-1:0] MAX_LINE_LENGTH_RESET  = 8'd254;

   typedef enum logic [2:0] {
      REG_SYNC_BYTE        = 3'd0,
      REG_TYPE_A_CODE      = 3'd1,
      REG_TYPE_B_CODE      = 3'd2,
      REG_TYPE_A_STAR_SLOT = 3'd3,
      REG_MAX_LINE_LENGTH  = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      VERDICT_NONE           = 3'd0,
      VERDICT_TYPE_A_OK      = 3'd1,
      VERDICT_TYPE_B_OK      = 3'd2,
      VERDICT_CHECKSUM_ERROR = 3'd3,
      VERDICT_UNRECOGNIZED   = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] sync_byte;
      logic [DATA_BITS-1:0] type_a_code;
      logic [DATA_BITS-1:0] type_b_code;
      logic [DATA_BITS-1:0] type_a_star_slot;
      logic [DATA_BITS-1:0] max_line_length;
   } cfg_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] data_byte;
      logic [DATA_BITS-1:0] byte_position;
      logic                 line_done;
      verdict_type          verdict;
      logic                 overflow_restart;
   } result_type;

endpackage

// ----- rtl/sfc_csr.sv -----
// ----------------------------------------------------------------------------
// sfc_csr
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module sfc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sfc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sfc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [sfc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   output sfc_pkg::cfg_type                  cfg
);

   sfc_pkg::cfg_type       cfg_ff, cfg_in;
   sfc_pkg::reg_index_type reg_index;
   logic                   wr_en;
   logic [sfc_pkg::DATA_BITS-1:0] wdata;

   assign csr_pready = 1'b1;
   assign reg_index  = sfc_pkg::reg_index_type'(csr_paddr[sfc_pkg::CSR_ADDR_BITS-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wdata      = csr_pwdata[sfc_pkg::DATA_BITS-1:0];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            sfc_pkg::REG_SYNC_BYTE:        cfg_in.sync_byte        = wdata;
            sfc_pkg::REG_TYPE_A_CODE:      cfg_in.type_a_code      = wdata;
            sfc_pkg::REG_TYPE_B_CODE:      cfg_in.type_b_code      = wdata;
            sfc_pkg::REG_TYPE_A_STAR_SLOT: cfg_in.type_a_star_slot = wdata;
            sfc_pkg::REG_MAX_LINE_LENGTH:  cfg_in.max_line_length  = wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_index)
         sfc_pkg::REG_SYNC_BYTE:
            csr_prdata = sfc_pkg::CSR_DATA_BITS'(cfg_ff.sync_byte);
         sfc_pkg::REG_TYPE_A_CODE:
            csr_prdata = sfc_pkg::CSR_DATA_BITS'(cfg_ff.type_a_code);
         sfc_pkg::REG_TYPE_B_CODE:
            csr_prdata = sfc_pkg::CSR_DATA_BITS'(cfg_ff.type_b_code);
         sfc_pkg::REG_TYPE_A_STAR_SLOT:
            csr_prdata = sfc_pkg::CSR_DATA_BITS'(cfg_ff.type_a_star_slot);
         sfc_pkg::REG_MAX_LINE_LENGTH:
            csr_prdata = sfc_pkg::CSR_DATA_BITS'(cfg_ff.max_line_length);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte        <= sfc_pkg::SYNC_BYTE_RESET;
         cfg_ff.type_a_code      <= sfc_pkg::TYPE_A_CODE_RESET;
         cfg_ff.type_b_code      <= sfc_pkg::TYPE_B_CODE_RESET;
         cfg_ff.type_a_star_slot <= sfc_pkg::TYPE_A_STAR_SLOT_RESET;
         cfg_ff.max_line_length  <= sfc_pkg::MAX_LINE_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/sfc_core.sv -----
// ----------------------------------------------------------------------------
// sfc_core
// per-line frame state and the verdict logic for one byte
// ----------------------------------------------------------------------------
module sfc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [sfc_pkg::DATA_BITS-1:0] rx_byte,
   input  sfc_pkg::cfg_type              cfg,
   output sfc_pkg::result_type           result
);

   localparam int unsigned PosBits = sfc_pkg::POSITION_BITS;
   localparam int unsigned CmpBits = sfc_pkg::CMP_BITS;
   localparam int unsigned ExtBits = sfc_pkg::CMP_EXT_BITS;

   logic [PosBits-1:0]            pos_ff, pos_in;
   logic [sfc_pkg::DATA_BITS-1:0] xor_ff, xor_in;
   logic                          star_seen_ff, star_seen_in;
   logic                          pending_ff, pending_in;
   logic [sfc_pkg::DATA_BITS-1:0] check_byte_ff, check_byte_in;
   logic                          captured_ff, captured_in;
   logic                          sync_ok_ff, sync_ok_in;
   logic [sfc_pkg::DATA_BITS-1:0] type_byte_ff, type_byte_in;
   logic                          slot_star_ff, slot_star_in;

   logic               is_nl;
   logic               is_star;
   logic [PosBits:0]   next_pos;
   logic               restart;
   logic               header_ok;
   logic               sum_ok;
   logic [CmpBits-1:0] pos_wide;
   sfc_pkg::verdict_type verdict;

   assign is_nl    = (rx_byte == sfc_pkg::NEWLINE_CODE);
   assign is_star  = (rx_byte == sfc_pkg::STAR_CODE);
   assign pos_wide = CmpBits'(pos_ff);
   assign next_pos = {1'b0, pos_ff} + (PosBits+1)'(1);
   assign restart  = !is_nl && ((ExtBits'(next_pos) >= ExtBits'(cfg.max_line_length))
                                || next_pos[PosBits]);

   always_comb begin
      sync_ok_in    = sync_ok_ff;
      type_byte_in  = type_byte_ff;
      slot_star_in  = slot_star_ff;
      xor_in        = xor_ff;
      star_seen_in  = star_seen_ff;
      pending_in    = pending_ff;
      check_byte_in = check_byte_ff;
      captured_in   = captured_ff;
      pos_in        = next_pos[PosBits-1:0];

      // header: two sync bytes then the type byte
      if (pos_ff == PosBits'(0)) begin
         sync_ok_in = (rx_byte == cfg.sync_byte);
      end else if (pos_ff == PosBits'(1)) begin
         sync_ok_in = sync_ok_ff && (rx_byte == cfg.sync_byte);
      end else if (pos_ff == PosBits'(2)) begin
         type_byte_in = rx_byte;
      end

      if ((pos_wide == CmpBits'(cfg.type_a_star_slot)) && is_star) begin
         slot_star_in = 1'b1;
      end

      // checksum: xor up to the first star, the next byte is the check value
      if (pending_ff) begin
         check_byte_in = rx_byte;
         captured_in   = 1'b1;
         pending_in    = 1'b0;
      end else if (!star_seen_ff) begin
         if (is_star) begin
            star_seen_in = 1'b1;
            pending_in   = 1'b1;
         end else begin
            xor_in = xor_ff ^ rx_byte;
         end
      end

      header_ok = sync_ok_in && (pos_ff >= PosBits'(2));
      sum_ok    = captured_in && (check_byte_in == xor_in);

      priority if (!is_nl) begin
         verdict = sfc_pkg::VERDICT_NONE;
      end else if (header_ok && (type_byte_in == cfg.type_a_code) && slot_star_in) begin
         verdict = sum_ok ? sfc_pkg::VERDICT_TYPE_A_OK : sfc_pkg::VERDICT_CHECKSUM_ERROR;
      end else if (header_ok && (type_byte_in == cfg.type_b_code)) begin
         verdict = sum_ok ? sfc_pkg::VERDICT_TYPE_B_OK : sfc_pkg::VERDICT_CHECKSUM_ERROR;
      end else begin
         verdict = sfc_pkg::VERDICT_UNRECOGNIZED;
      end

      // line end or length limit starts a fresh frame
      if (is_nl || restart) begin
         pos_in        = '0;
         xor_in        = '0;
         star_seen_in  = 1'b0;
         pending_in    = 1'b0;
         check_byte_in = '0;
         captured_in   = 1'b0;
         sync_ok_in    = 1'b0;
         type_byte_in  = '0;
         slot_star_in  = 1'b0;
      end
   end

   always_comb begin
      result.data_byte        = rx_byte;
      result.byte_position    = pos_wide[sfc_pkg::DATA_BITS-1:0];
      result.line_done        = is_nl;
      result.verdict          = verdict;
      result.overflow_restart = restart;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         xor_ff        <= '0;
         star_seen_ff  <= 1'b0;
         pending_ff    <= 1'b0;
         check_byte_ff <= '0;
         captured_ff   <= 1'b0;
         sync_ok_ff    <= 1'b0;
         type_byte_ff  <= '0;
         slot_star_ff  <= 1'b0;
      end else if (fire) begin
         pos_ff        <= pos_in;
         xor_ff        <= xor_in;
         star_seen_ff  <= star_seen_in;
         pending_ff    <= pending_in;
         check_byte_ff <= check_byte_in;
         captured_ff   <= captured_in;
         sync_ok_ff    <= sync_ok_in;
         type_byte_ff  <= type_byte_in;
         slot_star_ff  <= slot_star_in;
      end
   end

endmodule

// ----- rtl/serial_packet_frame_checker.sv -----
// ----------------------------------------------------------------------------
// serial_packet_frame_checker
// splits received bytes into newline-terminated lines, echoes each byte with
// its position and gives the line's verdict on the terminating newline
// ----------------------------------------------------------------------------
//   channel   ports                          direction  one transfer
//   req       req_valid/req_ready/req_*      in         one received byte
//   rsp       rsp_valid/rsp_ready/rsp_*      out        echo, position, verdict
//   csr       csr_psel/penable/pwrite/...    in         register read or write
//
// one item per cycle sustained while rsp_ready stays high; an accepted byte
// passes the input register, then the frame logic into the result register,
// before rsp_valid shows its echo
// the frame state update (position, running xor, header and star flags) is a
// single short combinational cone
// synchronous active-high reset clears the frame state and the valid flags of
// both pipeline registers and loads the default register values
// a stall on rsp holds the result register and the input register; req_ready
// drops only when both are full and rsp_ready is low
// ----------------------------------------------------------------------------
module serial_packet_frame_checker (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_data_byte,
   output logic [7:0]                        rsp_byte_position,
   output logic                              rsp_line_done,
   output logic [2:0]                        rsp_verdict,
   output logic                              rsp_overflow_restart,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sfc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sfc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [sfc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   sfc_pkg::cfg_type    cfg;
   sfc_pkg::result_type core_result;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic [sfc_pkg::DATA_BITS-1:0] in_byte_ff, in_byte_in;

   // result register
   logic                          out_valid_ff, out_valid_in;
   sfc_pkg::result_type           result_ff, result_in;

   logic out_free;
   logic advance;
   logic req_fire;

   // result slot is free when empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   sfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // frame state advances only when its byte moves into the result register
   sfc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         result_in    = core_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      result_ff  <= result_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_data_byte        = result_ff.data_byte;
   assign rsp_byte_position    = result_ff.byte_position;
   assign rsp_line_done        = result_ff.line_done;
   assign rsp_verdict          = result_ff.verdict;
   assign rsp_overflow_restart = result_ff.overflow_restart;

endmodule

// ----- rtl/sfc_checker.sv -----
// ----------------------------------------------------------------------------
// sfc_checker
// port-level checks of the frame checker, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic [7:0] rsp_byte_position,
   input logic       rsp_line_done,
   input logic [2:0] rsp_verdict,
   input logic       rsp_overflow_restart
);

   logic [20:0] rsp_payload;

   assign rsp_payload = {rsp_data_byte, rsp_byte_position, rsp_line_done, rsp_verdict,
                         rsp_overflow_restart};

   // a stalled result holds its payload
   `SFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload))

   // only the newline carries a verdict, and it is a defined code
   `SFC_ASSERT_IMPLY(a_done_verdict, clock, reset, rsp_valid && rsp_line_done,
      rsp_verdict != sfc_pkg::VERDICT_NONE && rsp_verdict <= sfc_pkg::VERDICT_UNRECOGNIZED)

   `SFC_ASSERT_IMPLY(a_mid_verdict, clock, reset, rsp_valid && !rsp_line_done,
      rsp_verdict == sfc_pkg::VERDICT_NONE)

   // a forced restart never coincides with a line end
   `SFC_ASSERT_IMPLY(a_restart_excl, clock, reset, rsp_valid && rsp_overflow_restart,
      !rsp_line_done && rsp_data_byte != sfc_pkg::NEWLINE_CODE)

   // with no result waiting and no byte offered, the input is free next cycle
   `SFC_ASSERT_NEXT(a_empty_ready, clock, reset, !rsp_valid && !req_valid, req_ready)

endmodule

bind serial_packet_frame_checker sfc_checker u_sfc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_data_byte        (rsp_data_byte),
   .rsp_byte_position    (rsp_byte_position),
   .rsp_line_done        (rsp_line_done),
   .rsp_verdict          (rsp_verdict),
   .rsp_overflow_restart (rsp_overflow_restart)
);

// ----- tb/tb_serial_packet_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_packet_frame_checker
// self-checking bench for the serial packet frame checker: a queue-fed driver
// streams received bytes, a byte-level line model predicts each echo,
// position and verdict, and a monitor compares every result item in order;
// register settings change between phases while the block is idle
// ----------------------------------------------------------------------------
module tb_serial_packet_frame_checker;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1100;
   localparam int POS_MAX     = (1 << sfc_pkg::POSITION_BITS) - 1;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // input channel
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;

   // result channel
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_byte_position;
   logic       rsp_line_done;
   logic [2:0] rsp_verdict;
   logic       rsp_overflow_restart;

   // configuration port
   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [sfc_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [sfc_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [sfc_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   serial_packet_frame_checker DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_byte_position    (rsp_byte_position),
      .rsp_line_done        (rsp_line_done),
      .rsp_verdict          (rsp_verdict),
      .rsp_overflow_restart (rsp_overflow_restart),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #1 clock = ~clock;

   // bytes still to be sent, and echoes still to come back
   logic [7:0]          rx_queue[$];
   sfc_pkg::result_type echo_expect_q[$];

   int  byte_total     = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  idle_pct       = 0;  // sender idle chance per cycle, percent
   int  stall_pct      = 0;  // receiver stall chance per cycle, percent
   logic req_taken     = 1'b0;

   // line model: register copy and per-line tracking state
   sfc_pkg::cfg_type                  cfg;
   logic [sfc_pkg::POSITION_BITS-1:0] line_pos;
   logic [7:0]                        run_xor;
   logic                              star_seen;
   logic                              check_pending;
   logic [7:0]                        check_byte;
   logic                              check_captured;
   logic                              sync_ok;
   logic [7:0]                        type_byte;
   logic                              slot_star_ok;

   // forget everything about the current line
   function automatic void clear_frame();
      line_pos       = '0;
      run_xor        = 8'h00;
      star_seen      = 1'b0;
      check_pending  = 1'b0;
      check_byte     = 8'h00;
      check_captured = 1'b0;
      sync_ok        = 1'b0;
      type_byte      = 8'h00;
      slot_star_ok   = 1'b0;
   endfunction

   // advance the line model by one received byte and return its echo
   function automatic sfc_pkg::result_type frame_step(input logic [7:0] rx);
      sfc_pkg::result_type r;
      int                  pos;
      int                  nxt;
      logic                header;
      logic                sum_ok;
      pos = int'(line_pos);
      // header: two sync bytes then the type byte
      if (pos == 0)
         sync_ok = (rx == cfg.sync_byte);
      else if (pos == 1)
         sync_ok = sync_ok && (rx == cfg.sync_byte);
      else if (pos == 2)
         type_byte = rx;
      if (pos == int'(cfg.type_a_star_slot) && rx == sfc_pkg::STAR_CODE)
         slot_star_ok = 1'b1;
      // xor runs up to the first star; the byte right after it is the check
      if (check_pending) begin
         check_byte     = rx;
         check_captured = 1'b1;
         check_pending  = 1'b0;
      end else if (!star_seen) begin
         if (rx == sfc_pkg::STAR_CODE) begin
            star_seen     = 1'b1;
            check_pending = 1'b1;
         end else begin
            run_xor = run_xor ^ rx;
         end
      end
      r.data_byte        = rx;
      r.byte_position    = 8'(pos);
      r.line_done        = (rx == sfc_pkg::NEWLINE_CODE);
      r.verdict          = sfc_pkg::VERDICT_NONE;
      r.overflow_restart = 1'b0;
      if (r.line_done) begin
         header = sync_ok && (pos >= 2);
         sum_ok = check_captured && (check_byte == run_xor);
         // type a wins when both codes match and the slot star is present
         if (header && type_byte == cfg.type_a_code && slot_star_ok)
            r.verdict = sum_ok ? sfc_pkg::VERDICT_TYPE_A_OK
                               : sfc_pkg::VERDICT_CHECKSUM_ERROR;
         else if (header && type_byte == cfg.type_b_code)
            r.verdict = sum_ok ? sfc_pkg::VERDICT_TYPE_B_OK
                               : sfc_pkg::VERDICT_CHECKSUM_ERROR;
         else
            r.verdict = sfc_pkg::VERDICT_UNRECOGNIZED;
         clear_frame();
      end else begin
         nxt = pos + 1;
         // length limit or position wrap restarts the frame
         if (nxt >= int'(cfg.max_line_length) || nxt > POS_MAX) begin
            r.overflow_restart = 1'b1;
            clear_frame();
         end else begin
            line_pos = sfc_pkg::POSITION_BITS'(nxt);
         end
      end
      return r;
   endfunction

   task automatic check_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // monitor: register writes, accepted bytes, returned echoes, timeout
   always @(posedge clock) begin
      sfc_pkg::result_type want;
      cycle_count <= cycle_count + 1;
      req_taken   <= req_valid && req_ready && !reset;
      if (reset) begin
         cfg.sync_byte        = sfc_pkg::SYNC_BYTE_RESET;
         cfg.type_a_code      = sfc_pkg::TYPE_A_CODE_RESET;
         cfg.type_b_code      = sfc_pkg::TYPE_B_CODE_RESET;
         cfg.type_a_star_slot = sfc_pkg::TYPE_A_STAR_SLOT_RESET;
         cfg.max_line_length  = sfc_pkg::MAX_LINE_LENGTH_RESET;
         clear_frame();
      end else begin
         // register write lands at the access phase
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (sfc_pkg::reg_index_type'(csr_paddr[4:2]))
               sfc_pkg::REG_SYNC_BYTE:        cfg.sync_byte        = csr_pwdata[7:0];
               sfc_pkg::REG_TYPE_A_CODE:      cfg.type_a_code      = csr_pwdata[7:0];
               sfc_pkg::REG_TYPE_B_CODE:      cfg.type_b_code      = csr_pwdata[7:0];
               sfc_pkg::REG_TYPE_A_STAR_SLOT: cfg.type_a_star_slot = csr_pwdata[7:0];
               sfc_pkg::REG_MAX_LINE_LENGTH:  cfg.max_line_length  = csr_pwdata[7:0];
               default: ;
            endcase
         end
         // every accepted byte yields exactly one echo item
         if (req_valid && req_ready)
            echo_expect_q.push_back(frame_step(req_rx_byte));
         if (rsp_valid && rsp_ready) begin
            if (echo_expect_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual byte %0h pos %0d",
                        $time, rsp_data_byte, rsp_byte_position);
               mismatch_count++;
            end else begin
               want = echo_expect_q.pop_front();
               check_field("data_byte", want.data_byte, rsp_data_byte);
               check_field("byte_position", want.byte_position, rsp_byte_position);
               check_field("line_done", 8'(want.line_done), 8'(rsp_line_done));
               check_field("verdict", 8'(want.verdict), 8'(rsp_verdict));
               check_field("overflow_restart", 8'(want.overflow_restart),
                           8'(rsp_overflow_restart));
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // driver: present the next byte once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (rx_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic csr_write(input sfc_pkg::reg_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'h000000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_regs(input logic [7:0] sync, input logic [7:0] code_a,
                               input logic [7:0] code_b, input logic [7:0] slot,
                               input logic [7:0] max_len);
      csr_write(sfc_pkg::REG_SYNC_BYTE, sync);
      csr_write(sfc_pkg::REG_TYPE_A_CODE, code_a);
      csr_write(sfc_pkg::REG_TYPE_B_CODE, code_b);
      csr_write(sfc_pkg::REG_TYPE_A_STAR_SLOT, slot);
      csr_write(sfc_pkg::REG_MAX_LINE_LENGTH, max_len);
   endtask

   // wait for all bytes sent and all echoes back, then let the pipe settle
   task automatic wait_idle();
      while (rx_queue.size() != 0 || req_valid || echo_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // payload byte that is neither a newline nor a star
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == sfc_pkg::NEWLINE_CODE || b == sfc_pkg::STAR_CODE);
      return b;
   endfunction

   // build one line against the current settings and queue its bytes
   task automatic queue_line();
      logic [7:0] line[$];
      logic [7:0] sum;
      int         pick;
      int         star_at;
      int         n;
      pick = $urandom_range(99);
      if (pick < 70) begin
         // framed packet, broken on purpose in the upper part of the range
         line.push_back(cfg.sync_byte);
         line.push_back(cfg.sync_byte);
         if (pick < 40) begin
            line.push_back(cfg.type_a_code);
            // far slots would make huge lines, so the star lands early instead
            star_at = (cfg.type_a_star_slot <= 40) ? int'(cfg.type_a_star_slot)
                                                   : $urandom_range(3, 8);
         end else begin
            line.push_back(cfg.type_b_code);
            star_at = $urandom_range(3, 10);
         end
         while (line.size() < star_at) line.push_back(body_byte());
         sum = 8'h00;
         foreach (line[i]) sum = sum ^ line[i];
         line.push_back(sfc_pkg::STAR_CODE);
         line.push_back(sum);
         n = $urandom_range(0, 4);
         repeat (n)
            line.push_back(($urandom_range(7) == 0) ? sfc_pkg::STAR_CODE : body_byte());
         if (pick >= 55) begin
            case ($urandom_range(2))
               0:       line[$urandom_range(line.size() - 1)] = 8'($urandom_range(255));
               1:       line.delete(star_at);
               default: line.delete(star_at + 1);
            endcase
         end
      end else if (pick < 92) begin
         // noise, sometimes with a plausible start
         if ($urandom_range(1) == 1) line.push_back(cfg.sync_byte);
         n = $urandom_range(0, 20);
         repeat (n) line.push_back(8'($urandom_range(255)));
      end else begin
         // long body run, at times past the length limit
         if (cfg.max_line_length <= 40)
            n = int'(cfg.max_line_length) - 2 + $urandom_range(0, 6);
         else if ($urandom_range(9) == 0)
            n = int'(cfg.max_line_length) + $urandom_range(0, 3);
         else
            n = $urandom_range(20, 40);
         repeat (n) line.push_back(body_byte());
      end
      line.push_back(sfc_pkg::NEWLINE_CODE);
      foreach (line[i]) rx_queue.push_back(line[i]);
      byte_total += line.size();
   endtask

   // stimulus and end of run
   initial begin
      int phase;
      int phase_end;
      logic [7:0] code_a;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed lines at reset settings: good type a, good type b,
      // type b without star, lone newline, newline right after the star
      rx_queue = '{8'hFF, 8'hFF, 8'hFB, 8'h00, 8'hFF, 8'h01, 8'h2A, 8'h05, 8'h0A,
                   8'hFF, 8'hFF, 8'hFD, 8'h2A, 8'hFD, 8'h0A,
                   8'hFF, 8'hFF, 8'hFD, 8'h80, 8'h0A,
                   8'h0A,
                   8'hFF, 8'hFF, 8'hFD, 8'h2A, 8'h0A};
      byte_total = rx_queue.size();

      phase = 0;
      while (byte_total < ITEM_TARGET) begin
         wait_idle();
         // idling mode rotates independently of the settings
         case ((phase + phase / 8) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         case (phase % 8)
            // low extremes: tight length limit, earliest star slot
            0: program_regs(8'h00, 8'h00, 8'hFF, 8'd3, 8'd8);
            // high extremes, equal codes, slot beyond any line
            1: program_regs(8'hFF, 8'hFF, 8'hFF, 8'd253, 8'd254);
            // star as sync byte and newline as type a code
            2: program_regs(sfc_pkg::STAR_CODE, sfc_pkg::NEWLINE_CODE, 8'h55, 8'd5, 8'd40);
            // equal type codes with a reachable slot
            3: program_regs(8'hA5, 8'h3C, 8'h3C, 8'd4, 8'd20);
            default: begin
               code_a = 8'($urandom_range(255));
               program_regs(8'($urandom_range(255)), code_a,
                            ($urandom_range(3) == 0) ? code_a : 8'($urandom_range(255)),
                            8'($urandom_range(3, 12)),
                            ($urandom_range(3) == 0) ? 8'($urandom_range(8, 20))
                                                     : 8'($urandom_range(8, 254)));
            end
         endcase
         phase_end = byte_total + 100;
         while (byte_total < phase_end) queue_line();
         phase++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && echo_expect_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
